// File: rtl/uer_pkg.sv
// Shared types, codes and constants for the ultrasonic echo ranger.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package uer_pkg;

    localparam int TICK_W     = 22;
    localparam int WIDTH_W    = 17;
    localparam int DIST_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam int AVG_DEPTH_DEF = 3;

    // register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_PAUSE  = 3'd7;

    // register reset values
    localparam logic [7:0]        RST_TRIG_LOW  = 8'd4;
    localparam logic [7:0]        RST_TRIG_HIGH = 8'd10;
    localparam logic [15:0]       RST_TIMEOUT   = 16'd30000;
    localparam logic [15:0]       RST_MIN_WIDTH = 16'd100;
    localparam logic [15:0]       RST_MAX_WIDTH = 16'd25000;
    localparam logic [15:0]       RST_SCALE     = 16'd1125;
    localparam logic [TICK_W-1:0] RST_PAUSE     = 22'd200000;
    localparam logic [TICK_W-1:0] RST_ERR_PAUSE = 22'd2000000;

    // result status codes
    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_NO_ECHO = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef enum logic [2:0] {
        PH_TRIG_LOW  = 3'd0,
        PH_TRIG_HIGH = 3'd1,
        PH_WAIT_ECHO = 3'd2,
        PH_MEASURE   = 3'd3,
        PH_PAUSE     = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0]        trig_low;
        logic [7:0]        trig_high;
        logic [15:0]       echo_timeout;
        logic [15:0]       min_width;
        logic [15:0]       max_width;
        logic [15:0]       scale;
        logic [TICK_W-1:0] pause;
        logic [TICK_W-1:0] err_pause;
    } t_cfg;

    // per-tick fields that travel unchanged down the pipe
    typedef struct packed {
        logic               trig;
        logic               done;
        logic [1:0]         status;
        logic [WIDTH_W-1:0] width;
    } t_res;

    // first stage output: result fields plus a distance to push
    typedef struct packed {
        t_res              res;
        logic              push;
        logic [DIST_W-1:0] dist_val;
    } t_meas;

endpackage

`default_nettype wire

// File: rtl/uer_ctrl.sv
// Trigger / echo sequencer and width-to-distance multiply (first pipe stage).
// Depends on uer_pkg.
`default_nettype none

module uer_ctrl import uer_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire logic  i_echo_level,
    input  wire t_cfg  i_cfg,
    output t_meas      o_meas
);

    t_phase             r_phase, n_phase;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [WIDTH_W-1:0] r_width, n_width;
    t_meas              r_meas;

    logic [TICK_W-1:0]  w_tick_inc;
    logic [TICK_W-1:0]  w_tick_dec;
    logic [WIDTH_W-1:0] w_width;
    logic [WIDTH_W-1:0] w_timeout;
    logic               w_trig;
    logic               w_finish;
    logic               w_no_echo;
    logic               w_good;
    logic [32:0]        w_prod;

    assign w_tick_inc = r_tick + TICK_W'(1);
    assign w_tick_dec = (r_tick == '0) ? '0 : r_tick - TICK_W'(1);
    assign w_timeout  = WIDTH_W'(i_cfg.echo_timeout);

    // decode of this tick: trigger drive and end of measurement
    always_comb begin
        w_trig    = 1'b0;
        w_finish  = 1'b0;
        w_no_echo = 1'b0;
        w_width   = '0;
        case (r_phase)
            PH_TRIG_HIGH: begin
                w_trig = 1'b1;
            end
            PH_WAIT_ECHO: begin
                if (i_echo_level) begin
                    w_width  = WIDTH_W'(1);
                    w_finish = (WIDTH_W'(1) > w_timeout);
                end else begin
                    w_no_echo = (w_tick_inc > TICK_W'(i_cfg.echo_timeout));
                end
            end
            PH_MEASURE: begin
                if (i_echo_level) begin
                    w_width  = r_width + WIDTH_W'(1);
                    w_finish = (w_width > w_timeout);
                end else begin
                    w_width  = r_width;
                    w_finish = 1'b1;
                end
            end
            default: begin
            end
        endcase
        w_good = w_finish && !(w_width > WIDTH_W'(i_cfg.max_width) ||
                               w_width < WIDTH_W'(i_cfg.min_width));
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_width = r_width;
        case (r_phase)
            PH_TRIG_HIGH: begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= TICK_W'(i_cfg.trig_high)) begin
                    n_phase = PH_WAIT_ECHO;
                    n_tick  = '0;
                end
            end
            PH_WAIT_ECHO: begin
                if (i_echo_level) begin
                    n_phase = PH_MEASURE;
                    n_width = WIDTH_W'(1);
                    n_tick  = '0;
                end else if (w_no_echo) begin
                    n_phase = (i_cfg.err_pause == '0) ? PH_TRIG_LOW : PH_PAUSE;
                    n_tick  = i_cfg.err_pause;
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            PH_MEASURE: begin
                if (i_echo_level) begin
                    n_width = r_width + WIDTH_W'(1);
                end
            end
            PH_PAUSE: begin
                n_tick = w_tick_dec;
                if (w_tick_dec == '0) begin
                    n_phase = PH_TRIG_LOW;
                end
            end
            default: begin
                // unused codes behave as trigger low
                n_phase = PH_TRIG_LOW;
                n_tick  = w_tick_inc;
                if (w_tick_inc >= TICK_W'(i_cfg.trig_low)) begin
                    n_phase = PH_TRIG_HIGH;
                    n_tick  = '0;
                end
            end
        endcase
        if (w_finish) begin
            n_width = '0;
            if (w_good) begin
                n_phase = (i_cfg.pause == '0) ? PH_TRIG_LOW : PH_PAUSE;
                n_tick  = i_cfg.pause;
            end else begin
                n_phase = PH_TRIG_LOW;
                n_tick  = '0;
            end
        end
    end

    assign w_prod = 33'(w_width) * 33'(i_cfg.scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TRIG_LOW;
            r_tick  <= '0;
            r_width <= '0;
        end else if (i_load) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_width <= n_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_meas.res.trig   <= w_trig;
            r_meas.res.done   <= w_finish || w_no_echo;
            r_meas.res.status <= w_no_echo ? ST_NO_ECHO :
                                 !w_finish ? ST_BUSY    :
                                 w_good    ? ST_VALID   : ST_INVALID;
            r_meas.res.width  <= w_finish ? w_width : '0;
            r_meas.push       <= w_good;
            r_meas.dist_val   <= w_prod[DIST_W+7:8];
        end
    end

    assign o_meas = r_meas;

endmodule

`default_nettype wire

// File: rtl/uer_avg.sv
// History of accepted distances with a running sum (second pipe stage).
// Depends on uer_pkg.
`default_nettype none

module uer_avg import uer_pkg::*; #(
    parameter int AVERAGE_DEPTH = AVG_DEPTH_DEF,
    localparam int SumW = DIST_W + $clog2(AVERAGE_DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire t_meas           i_meas,
    output t_res                 o_res,
    output logic [SumW-1:0]      o_sum,
    output logic [DIST_W-1:0]    o_last
);

    logic [DIST_W-1:0] r_hist [AVERAGE_DEPTH];
    logic [SumW-1:0]   r_sum;
    logic [DIST_W-1:0] r_last;
    t_res              r_res;
    logic [SumW-1:0]   n_sum;

    // newest enters, oldest drops out of the sum
    assign n_sum = r_sum + SumW'(i_meas.dist_val) - SumW'(r_hist[AVERAGE_DEPTH-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AVERAGE_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_load && i_meas.push) begin
            r_hist[0] <= i_meas.dist_val;
            for (int i = 1; i < AVERAGE_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_sum  <= n_sum;
            r_last <= i_meas.dist_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_meas.res;
        end
    end

    assign o_res  = r_res;
    assign o_sum  = r_sum;
    assign o_last = r_last;

endmodule

`default_nettype wire

// File: rtl/uer_div.sv
// Mean of the history by reciprocal multiply, and the result register (last stage).
// Depends on uer_pkg.
`default_nettype none

module uer_div import uer_pkg::*; #(
    parameter int AVERAGE_DEPTH = AVG_DEPTH_DEF,
    localparam int SumW = DIST_W + $clog2(AVERAGE_DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_load,
    input  wire t_res               i_res,
    input  wire logic [SumW-1:0]    i_sum,
    input  wire logic [DIST_W-1:0]  i_last,
    output t_res                    o_res,
    output logic [DIST_W-1:0]       o_dist,
    output logic [DIST_W-1:0]       o_avg
);

    // floor(x / D) == (x * ceil(2^(SumW+L) / D)) >> (SumW+L) for x < 2^SumW
    localparam int              Shift   = SumW + $clog2(AVERAGE_DEPTH);
    localparam longint unsigned RecipL  =
        ((64'd1 << Shift) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
    localparam logic [SumW:0]   Recip   = (SumW+1)'(RecipL);
    localparam int              ProdW   = 2 * SumW + 1;

    logic [ProdW-1:0]  w_prod;
    t_res              r_res;
    logic [DIST_W-1:0] r_dist;
    logic [DIST_W-1:0] r_avg;

    assign w_prod = ProdW'(i_sum) * ProdW'(Recip);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res  <= i_res;
            r_dist <= i_last;
            r_avg  <= w_prod[Shift +: DIST_W];
        end
    end

    assign o_res  = r_res;
    assign o_dist = r_dist;
    assign o_avg  = r_avg;

endmodule

`default_nettype wire

// File: rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level: register file, pipe control, three stages.
// Depends on uer_pkg, uer_ctrl, uer_avg, uer_div.
//
// One input beat is one 1 us tick carrying the sampled echo level; every accepted
// tick gives exactly one result beat once it has passed through each stage in turn.
// A tick is taken every clock cycle unless o_stall is high: the sequencer and the
// 17x16 width-by-scale multiply sit in the first stage, the distance history and its
// running sum in the second, and the reciprocal multiply that forms the mean in
// the third. Any stage holds its beat while the one after it is full and stalled.
// Registers are live and should be written only while the pipe is empty.
`default_nettype none

module ultrasonic_echo_ranger import uer_pkg::*; #(
    parameter int AVERAGE_DEPTH = AVG_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_echo_level,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_trig_level,
    output logic                       o_done_res,
    output logic [1:0]                 o_status,
    output logic [WIDTH_W-1:0]         o_echo_width,
    output logic [DIST_W-1:0]          o_distance,
    output logic [DIST_W-1:0]          o_average_distance
);

    localparam int SumW = DIST_W + $clog2(AVERAGE_DEPTH);

    t_cfg              r_cfg;
    logic              r_v1, r_v2, r_v3;
    logic              n_v1, n_v2, n_v3;
    logic              w_rdy1, w_rdy2, w_rdy3;
    logic              w_accept, w_move12, w_move23;
    t_meas             w_meas;
    t_res              w_res2, w_res3;
    logic [SumW-1:0]   w_sum;
    logic [DIST_W-1:0] w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_low     <= RST_TRIG_LOW;
            r_cfg.trig_high    <= RST_TRIG_HIGH;
            r_cfg.echo_timeout <= RST_TIMEOUT;
            r_cfg.min_width    <= RST_MIN_WIDTH;
            r_cfg.max_width    <= RST_MAX_WIDTH;
            r_cfg.scale        <= RST_SCALE;
            r_cfg.pause        <= RST_PAUSE;
            r_cfg.err_pause    <= RST_ERR_PAUSE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_TRIG_LOW:  r_cfg.trig_low     <= i_cfg_wdata[7:0];
                REG_TRIG_HIGH: r_cfg.trig_high    <= i_cfg_wdata[7:0];
                REG_TIMEOUT:   r_cfg.echo_timeout <= i_cfg_wdata[15:0];
                REG_MIN_WIDTH: r_cfg.min_width    <= i_cfg_wdata[15:0];
                REG_MAX_WIDTH: r_cfg.max_width    <= i_cfg_wdata[15:0];
                REG_SCALE:     r_cfg.scale        <= i_cfg_wdata[15:0];
                REG_PAUSE:     r_cfg.pause        <= i_cfg_wdata;
                REG_ERR_PAUSE: r_cfg.err_pause    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // each stage moves on when the next one is empty or moving itself
    assign w_rdy3   = !r_v3 || !i_stall;
    assign w_rdy2   = !r_v2 || w_rdy3;
    assign w_rdy1   = !r_v1 || w_rdy2;
    assign w_accept = i_valid && w_rdy1;
    assign w_move12 = r_v1 && w_rdy2;
    assign w_move23 = r_v2 && w_rdy3;

    assign n_v1 = w_accept || (r_v1 && !w_rdy2);
    assign n_v2 = w_move12 || (r_v2 && !w_rdy3);
    assign n_v3 = w_move23 || (r_v3 && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    uer_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_accept),
        .i_echo_level (i_echo_level),
        .i_cfg        (r_cfg),
        .o_meas       (w_meas)
    );

    uer_avg #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_move12),
        .i_meas  (w_meas),
        .o_res   (w_res2),
        .o_sum   (w_sum),
        .o_last  (w_last)
    );

    uer_div #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_load  (w_move23),
        .i_res   (w_res2),
        .i_sum   (w_sum),
        .i_last  (w_last),
        .o_res   (w_res3),
        .o_dist  (o_distance),
        .o_avg   (o_average_distance)
    );

    assign o_stall      = !w_rdy1;
    assign o_valid      = r_v3;
    assign o_trig_level = w_res3.trig;
    assign o_done_res   = w_res3.done;
    assign o_status     = w_res3.status;
    assign o_echo_width = w_res3.width;

    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_done_res == (o_status != ST_BUSY)))
        else $error("done flag disagrees with status");

    a_width_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_BUSY || o_status == ST_NO_ECHO)
            |-> (o_echo_width == '0))
        else $error("echo width reported without a width result");

    a_trig_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_trig_level |-> !o_done_res)
        else $error("measurement ended during trigger pulse");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_v3 && i_stall |=> r_v2 && $stable(w_sum))
        else $error("history changed while its beat was held");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking bench for ultrasonic_echo_ranger: drives echo ticks, predicts every result beat.
// Depends on uer_pkg and the ranger RTL; needs no files or arguments at run time.
`default_nettype none

module tb;
    import uer_pkg::*;

    typedef struct packed {
        t_res              res;
        logic [DIST_W-1:0] dist_val;
        logic [DIST_W-1:0] avg;
    } range_beat_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_echo_level;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_trig_level;
    logic                  o_done_res;
    logic [1:0]            o_status;
    logic [WIDTH_W-1:0]    o_echo_width;
    logic [DIST_W-1:0]     o_distance;
    logic [DIST_W-1:0]     o_average_distance;

    ultrasonic_echo_ranger uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_echo_level       (i_echo_level),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_trig_level       (o_trig_level),
        .o_done_res         (o_done_res),
        .o_status           (o_status),
        .o_echo_width       (o_echo_width),
        .o_distance         (o_distance),
        .o_average_distance (o_average_distance)
    );

    // ranger state as the bench sees it
    t_cfg               m_cfg;
    t_phase             m_phase;
    logic [TICK_W-1:0]  m_ticks;
    logic [WIDTH_W-1:0] m_width;
    logic [DIST_W-1:0]  m_history [AVG_DEPTH_DEF];
    int                 m_slot;

    range_beat_t expected_beats [$];
    int          fail_count;
    int          ranging_ticks;   // ticks sent while waiting for or measuring an echo
    bit          tx_idle_en;
    bit          rx_idle_en;
    int          rx_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("[ultrasonic_echo_ranger] ERROR");
        $finish;
    end

    function automatic void start_pause(input logic [TICK_W-1:0] len);
        if (len == '0) begin
            m_phase = PH_TRIG_LOW;
            m_ticks = '0;
        end else begin
            m_phase = PH_PAUSE;
            m_ticks = len;
        end
    endfunction

    function automatic range_beat_t step_ranger(input logic echo);
        range_beat_t         b;
        logic                finish;
        logic [WIDTH_W+15:0] prod;
        logic [DIST_W+1:0]   sum;
        int                  last;
        b = '0;
        finish = 1'b0;
        b.res.status = ST_BUSY;
        case (m_phase)
            PH_TRIG_HIGH: begin
                b.res.trig = 1'b1;
                m_ticks++;
                if (m_ticks >= m_cfg.trig_high) begin
                    m_phase = PH_WAIT_ECHO;
                    m_ticks = '0;
                end
            end
            PH_WAIT_ECHO: begin
                if (echo) begin
                    m_phase = PH_MEASURE;
                    m_width = WIDTH_W'(1);
                    m_ticks = '0;
                    finish  = (m_width > m_cfg.echo_timeout);
                end else begin
                    m_ticks++;
                    if (m_ticks > m_cfg.echo_timeout) begin
                        b.res.done   = 1'b1;
                        b.res.status = ST_NO_ECHO;
                        start_pause(m_cfg.err_pause);
                    end
                end
            end
            PH_MEASURE: begin
                if (echo) begin
                    m_width++;
                    finish = (m_width > m_cfg.echo_timeout);
                end else begin
                    finish = 1'b1;
                end
            end
            PH_PAUSE: begin
                if (m_ticks != '0) m_ticks--;
                if (m_ticks == '0) m_phase = PH_TRIG_LOW;
            end
            default: begin
                m_ticks++;
                if (m_ticks >= m_cfg.trig_low) begin
                    m_phase = PH_TRIG_HIGH;
                    m_ticks = '0;
                end
            end
        endcase

        if (finish) begin
            b.res.done  = 1'b1;
            b.res.width = m_width;
            if (m_width > m_cfg.max_width || m_width < m_cfg.min_width) begin
                b.res.status = ST_INVALID;
                m_phase = PH_TRIG_LOW;
                m_ticks = '0;
            end else begin
                prod = m_width * m_cfg.scale;
                b.res.status = ST_VALID;
                m_history[m_slot] = prod[DIST_W+7:8];
                m_slot = (m_slot == AVG_DEPTH_DEF - 1) ? 0 : m_slot + 1;
                start_pause(m_cfg.pause);
            end
            m_width = '0;
        end

        sum = '0;
        foreach (m_history[i]) sum += m_history[i];
        last = (m_slot == 0) ? AVG_DEPTH_DEF - 1 : m_slot - 1;
        b.dist_val = m_history[last];
        b.avg  = DIST_W'(sum / AVG_DEPTH_DEF);
        return b;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 200)
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // result side: compare every accepted beat with the oldest prediction
    initial begin : result_checker
        range_beat_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
                if (expected_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 200)
                        $display("%0t: expected no beat, got status %0d width %0d",
                                 $time, o_status, o_echo_width);
                end else begin
                    want = expected_beats.pop_front();
                    check_field("trig_level", want.res.trig, o_trig_level);
                    check_field("done_res", want.res.done, o_done_res);
                    check_field("status", want.res.status, o_status);
                    check_field("echo_width", want.res.width, o_echo_width);
                    check_field("distance", want.dist_val, o_distance);
                    check_field("average_distance", want.avg, o_average_distance);
                end
            end
        end
    end

    // output stall: random bursts, or a long hold when a test asks for one
    initial begin : stall_driver
        int stall_left;
        stall_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                stall_left = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_tick(input logic echo);
        int gap;
        if (m_phase == PH_WAIT_ECHO || m_phase == PH_MEASURE) ranging_ticks++;
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_echo_level <= echo;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        expected_beats.push_back(step_ranger(echo));
        @(negedge i_clk);
    endtask

    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_TRIG_LOW:  m_cfg.trig_low     = value[7:0];
            REG_TRIG_HIGH: m_cfg.trig_high    = value[7:0];
            REG_TIMEOUT:   m_cfg.echo_timeout = value[15:0];
            REG_MIN_WIDTH: m_cfg.min_width    = value[15:0];
            REG_MAX_WIDTH: m_cfg.max_width    = value[15:0];
            REG_SCALE:     m_cfg.scale        = value[15:0];
            REG_PAUSE:     m_cfg.pause        = value;
            REG_ERR_PAUSE: m_cfg.err_pause    = value;
            default: ;
        endcase
    endtask

    task automatic apply_setup(input logic [CFG_DATA_W-1:0] trig_lo, trig_hi, timeout,
                               min_w, max_w, scale, pause, err_pause);
        drain_pipe();
        write_reg(REG_TRIG_LOW, trig_lo);
        write_reg(REG_TRIG_HIGH, trig_hi);
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_MIN_WIDTH, min_w);
        write_reg(REG_MAX_WIDTH, max_w);
        write_reg(REG_SCALE, scale);
        write_reg(REG_PAUSE, pause);
        write_reg(REG_ERR_PAUSE, err_pause);
    endtask

    // trigger phases and pauses ignore the echo, so feed them noise
    task automatic run_to_wait();
        while (m_phase != PH_WAIT_ECHO) send_tick(1'($urandom_range(0, 1)));
    endtask

    // one measurement: lead low ticks, then width high ticks, then the falling edge
    task automatic echo_pulse(input int lead, input int width);
        run_to_wait();
        for (int i = 0; i < lead && m_phase == PH_WAIT_ECHO; i++) send_tick(1'b0);
        for (int i = 0; i < width && (m_phase == PH_WAIT_ECHO || m_phase == PH_MEASURE); i++)
            send_tick(1'b1);
        if (m_phase == PH_MEASURE) send_tick(1'b0);
    endtask

    // reset values: trigger timing, then a short echo that the filter rejects
    task automatic test_default_setup();
        echo_pulse(0, 50);
    endtask

    // both ends of the width window, timeout while measuring, no echo at all;
    // upper data bits on the 8-bit registers must be dropped
    task automatic test_width_filter();
        apply_setup(22'h3FFF00, 22'h3FFF01, 40, 3, 20, 65535, 0, 5);
        echo_pulse(0, 2);
        echo_pulse(1, 3);
        echo_pulse(0, 20);
        echo_pulse(2, 21);
        echo_pulse(0, 41);
        echo_pulse(0, 7);
        echo_pulse(0, 12);
        echo_pulse(41, 0);
        echo_pulse(3, 19);
    endtask

    task automatic test_timeout_zero();
        apply_setup(2, 3, 0, 0, 65535, 0, 3, 0);
        echo_pulse(0, 1);
        echo_pulse(1, 0);
        echo_pulse(0, 1);
    endtask

    // min above max: every width is rejected, so the huge pauses are never entered
    task automatic test_rejects_all();
        apply_setup(1, 1, 60, 50, 10, 4321, 22'h3FFFFF, 22'h3FFFFF);
        echo_pulse(0, 5);
        echo_pulse(3, 30);
        echo_pulse(0, 55);
        echo_pulse(0, 60);
        echo_pulse(0, 61);
    endtask

    // largest scale, echo ending on its own and echo cut off by the timeout
    task automatic test_long_echo();
        apply_setup(3, 4, 80, 0, 65535, 65535, 0, 0);
        echo_pulse(0, 80);
        echo_pulse(0, 81);
    endtask

    task automatic test_backpressure();
        apply_setup(1, 2, 20, 1, 20, 300, 0, 0);
        tx_idle_en = 1'b0;
        rx_hold_cycles = 64;
        for (int i = 0; i < 12; i++) echo_pulse($urandom_range(0, 3), $urandom_range(1, 22));
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_ranging(input int rounds, input int per_round);
        int tmo, mn, mx, target, pick, w, lead;
        for (int r = 0; r < rounds; r++) begin
            tmo = $urandom_range(0, 60);
            mn  = $urandom_range(0, 30);
            mx  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60) : mn + $urandom_range(0, 30);
            apply_setup($urandom_range(0, 5), $urandom_range(1, 5), tmo, mn, mx,
                        (r == 1) ? 65535 : $urandom_range(0, 65535),
                        $urandom_range(0, 12), $urandom_range(0, 12));
            if (r == rounds - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            target = ranging_ticks + per_round;
            while (ranging_ticks < target) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)));
                end else begin
                    pick = $urandom_range(0, 6);
                    case (pick)
                        0: w = mn;
                        1: w = (mn > 0) ? mn - 1 : 1;
                        2: w = mx;
                        3: w = mx + 1;
                        4: w = tmo + 1;
                        default: w = $urandom_range(1, tmo + 2);
                    endcase
                    lead = ($urandom_range(0, 5) == 0) ? tmo + 1 : $urandom_range(0, 5);
                    echo_pulse(lead, w);
                end
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_echo_level = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_addr   = REG_TRIG_LOW;
        i_cfg_wdata  = '0;
        fail_count     = 0;
        ranging_ticks  = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        rx_hold_cycles = 0;

        m_cfg = '{trig_low: RST_TRIG_LOW, trig_high: RST_TRIG_HIGH,
                  echo_timeout: RST_TIMEOUT, min_width: RST_MIN_WIDTH,
                  max_width: RST_MAX_WIDTH, scale: RST_SCALE,
                  pause: RST_PAUSE, err_pause: RST_ERR_PAUSE};
        m_phase = PH_TRIG_LOW;
        m_ticks = '0;
        m_width = '0;
        m_slot  = 0;
        foreach (m_history[i]) m_history[i] = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_setup();
        test_width_filter();
        test_timeout_zero();
        test_rejects_all();
        test_backpressure();
        test_long_echo();
        test_random_ranging(3, 50);

        drain_pipe();
        if (fail_count == 0)
            $display("[ultrasonic_echo_ranger] OK");
        else
            $display("[ultrasonic_echo_ranger] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/uer_pkg.sv
rtl/uer_ctrl.sv
rtl/uer_avg.sv
rtl/uer_div.sv
rtl/ultrasonic_echo_ranger.sv
tb/tb.sv
